### hw/rtl/intel_hex_record_parser_core_assert.svh
// Assertion macros for the Intel HEX parser checks.
// Both expect clk and rst_n to be visible where they are used.
`ifndef INTEL_HEX_RECORD_PARSER_CORE_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/ihex_pkg.sv
package ihex_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] EOL_CHAR   = 8'h00;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_CKSUM,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_OK      = 3'd1,
        K_EOF     = 3'd2,
        K_FORMAT  = 3'd3,
        K_CKSUM   = 3'd4,
        K_UNKNOWN = 3'd5
    } kind_t;

    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;

    // Returns {is_hex, nibble}; accepts upper and lower case digits.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

### hw/rtl/intel_hex_record_parser_core.sv
// Intel HEX record parser.
// The slave stream carries one ASCII character per request in s_axis_tdata;
// a zero character ends a line. The master stream carries one result per
// request: tuser holds the result kind (data byte, record ok, end of file,
// format error, checksum mismatch, unknown type) and tdata the target
// address and data byte. Data bytes leave before the checksum is known, so
// the receiver drops a record's bytes when a checksum mismatch follows.
// A character is decoded while it sits in the input register, and its result
// is loaded into the output register as the character advances. While the
// receiver takes results, one character is accepted every cycle; the per-character
// work is a hex decode and an 8-bit add between those two registers.
// Characters that produce no result simply pass through without a request
// on the master side.
// Reset clears the parser to waiting for a colon and empties both registers.
// When the receiver stalls, the pending result holds and the input register
// keeps one character; s_axis_tready then drops until the result is taken.
module intel_hex_record_parser_core
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] target_address, [23:16] data_byte
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);

    logic        in_valid_reg;
    logic [7:0]  ch_reg;
    logic        advance;

    phase_t      phase_reg, phase_next;
    logic [1:0]  digit_reg, digit_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  done_reg, done_next;
    logic [7:0]  sum_reg, sum_next;

    logic        emit;
    kind_t       res_kind;
    logic [15:0] res_addr;
    logic [7:0]  res_byte;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg;
    logic [15:0] out_addr_reg;
    logic [7:0]  out_byte_reg;

    logic [4:0]  hex;
    logic [15:0] acc_shift;
    logic [7:0]  val8;
    logic        last_digit;
    logic [7:0]  done_inc;

    assign advance       = in_valid_reg && !(out_valid_reg && !m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign hex        = hex_decode(ch_reg);
    assign acc_shift  = {acc_reg[11:0], hex[3:0]};
    assign val8       = acc_shift[7:0];
    assign last_digit = (phase_reg == PH_ADDR) ? (digit_reg == 2'd3) : (digit_reg == 2'd1);
    assign done_inc   = done_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        done_next  = done_reg;
        sum_next   = sum_reg;
        emit       = 1'b0;
        res_kind   = K_DATA;
        res_addr   = addr_reg;
        res_byte   = 8'd0;

        case (phase_reg)
            PH_WAIT:
            begin
                digit_next = 2'd0;
                acc_next   = 16'd0;
                count_next = 8'd0;
                addr_next  = 16'd0;
                done_next  = 8'd0;
                sum_next   = 8'd0;
                if (ch_reg == COLON_CHAR)
                begin
                    phase_next = PH_COUNT;
                end
                else
                begin
                    phase_next = (ch_reg == EOL_CHAR) ? PH_WAIT : PH_SKIP;
                    emit       = 1'b1;
                    res_kind   = K_FORMAT;
                    res_addr   = 16'd0;
                end
            end
            PH_SKIP:
            begin
                if (ch_reg == EOL_CHAR)
                begin
                    phase_next = PH_WAIT;
                end
            end
            default:
            begin
                if (ch_reg == EOL_CHAR)
                begin
                    phase_next = PH_WAIT;
                    emit       = 1'b1;
                    res_kind   = K_FORMAT;
                end
                else if (!hex[4])
                begin
                    phase_next = PH_SKIP;
                    emit       = 1'b1;
                    res_kind   = K_FORMAT;
                end
                else if (!last_digit)
                begin
                    digit_next = digit_reg + 2'd1;
                    acc_next   = acc_shift;
                end
                else
                begin
                    digit_next = 2'd0;
                    acc_next   = 16'd0;
                    case (phase_reg)
                        PH_COUNT:
                        begin
                            count_next = val8;
                            sum_next   = sum_reg + val8;
                            phase_next = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            addr_next  = acc_shift;
                            sum_next   = sum_reg + acc_shift[7:0] + acc_shift[15:8];
                            phase_next = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            sum_next = sum_reg + val8;
                            if (val8 == TYPE_DATA)
                            begin
                                phase_next = (count_reg != 8'd0) ? PH_DATA : PH_CKSUM;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                                emit       = 1'b1;
                                res_kind   = (val8 == TYPE_EOF) ? K_EOF : K_UNKNOWN;
                            end
                        end
                        PH_DATA:
                        begin
                            sum_next  = sum_reg + val8;
                            emit      = 1'b1;
                            res_kind  = K_DATA;
                            res_addr  = addr_reg + {8'd0, done_reg};
                            res_byte  = val8;
                            done_next = done_inc;
                            if (done_inc == count_reg)
                            begin
                                phase_next = PH_CKSUM;
                            end
                        end
                        default:
                        begin
                            // Checksum field: the byte sum over the whole record must be zero.
                            phase_next = PH_SKIP;
                            emit       = 1'b1;
                            res_kind   = ((sum_reg + val8) == 8'd0) ? K_OK : K_CKSUM;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_WAIT;
            digit_reg     <= 2'd0;
            acc_reg       <= 16'd0;
            count_reg     <= 8'd0;
            addr_reg      <= 16'd0;
            done_reg      <= 8'd0;
            sum_reg       <= 8'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                digit_reg <= digit_next;
                acc_reg   <= acc_next;
                count_reg <= count_next;
                addr_reg  <= addr_next;
                done_reg  <= done_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            ch_reg <= s_axis_tdata;
        end
        if (advance && emit)
        begin
            out_kind_reg <= res_kind;
            out_addr_reg <= res_addr;
            out_byte_reg <= res_byte;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_byte_reg, out_addr_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

### hw/rtl/ihex_chk.sv
`include "intel_hex_record_parser_core_assert.svh"

module ihex_chk
    import ihex_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic out_is_status;

    assign out_is_status = (m_axis_tuser != K_DATA);

    // Only the six defined result kinds may leave the block.
    `CHK_IMPLY(a_kind_range, m_axis_tvalid, m_axis_tuser <= K_UNKNOWN, "result kind out of range")

    // Status results never carry a data byte.
    `CHK_IMPLY(a_status_byte_zero, m_axis_tvalid && out_is_status, m_axis_tdata[23:16] == 8'd0, "status result with nonzero data byte")

    // A stalled result holds its valid and payload.
    `CHK_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // A result only disappears after the receiver has taken it.
    `CHK_IMPLY(a_drop_after_take, $fell(m_axis_tvalid), $past(m_axis_tready), "result withdrawn without a take")

    // With no result waiting, the input side is always open.
    `CHK_IMPLY(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with no result waiting")

endmodule

bind intel_hex_record_parser_core ihex_chk u_ihex_chk (.*);

### dv/intel_hex_record_parser_core_test.sv
module intel_hex_record_parser_core_test;
    import ihex_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_CHARS = 400;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        LINE_GOOD,
        LINE_BAD_SUM,
        LINE_EOF,
        LINE_UNKNOWN,
        LINE_BAD_DIGIT,
        LINE_SHORT,
        LINE_NO_COLON,
        LINE_EMPTY,
        LINE_NOISE
    } line_style_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } parse_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    logic [7:0]    char_q[$];
    logic [7:0]    line_buf[$];
    parse_result_t pending_results[$];
    parse_result_t oldest;

    int mismatch_count = 0;
    int chars_accepted = 0;
    int cycle_count    = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit calm           = 1'b0;

    // Parser state mirrored on the testbench side.
    phase_t      parse_phase;
    logic [1:0]  digit_idx;
    logic [15:0] field_acc;
    logic [7:0]  rec_count;
    logic [15:0] rec_addr;
    logic [7:0]  rec_bytes;
    logic [7:0]  rec_sum;

    intel_hex_record_parser_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    function automatic int nibble_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c - 8'h41) + 10;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c - 8'h61) + 10;
        return -1;
    endfunction

    task automatic clear_record();
        digit_idx = 2'd0;
        field_acc = 16'h0000;
        rec_count = 8'h00;
        rec_addr  = 16'h0000;
        rec_bytes = 8'h00;
        rec_sum   = 8'h00;
    endtask

    task automatic expect_result(kind_t k, logic [15:0] a, logic [7:0] d);
        pending_results.push_back('{kind: k, addr: a, data: d});
    endtask

    task automatic parse_char(input logic [7:0] c);
        int          nib;
        int          need;
        logic [15:0] value;
        logic [7:0]  total;
        if (parse_phase == PH_WAIT)
        begin
            clear_record();
            if (c == COLON_CHAR)
            begin
                parse_phase = PH_COUNT;
            end
            else
            begin
                // An empty line starts over at once; anything else skips the line.
                parse_phase = (c == EOL_CHAR) ? PH_WAIT : PH_SKIP;
                expect_result(K_FORMAT, 16'h0000, 8'h00);
            end
        end
        else if (parse_phase == PH_SKIP)
        begin
            if (c == EOL_CHAR)
                parse_phase = PH_WAIT;
        end
        else if (c == EOL_CHAR)
        begin
            parse_phase = PH_WAIT;
            expect_result(K_FORMAT, rec_addr, 8'h00);
        end
        else
        begin
            nib = nibble_of(c);
            if (nib < 0)
            begin
                parse_phase = PH_SKIP;
                expect_result(K_FORMAT, rec_addr, 8'h00);
            end
            else
            begin
                field_acc = {field_acc[11:0], 4'(nib)};
                need = (parse_phase == PH_ADDR) ? 4 : 2;
                if (int'(digit_idx) + 1 < need)
                begin
                    digit_idx = digit_idx + 2'd1;
                end
                else
                begin
                    value     = field_acc;
                    digit_idx = 2'd0;
                    field_acc = 16'h0000;
                    case (parse_phase)
                        PH_COUNT:
                        begin
                            rec_count   = value[7:0];
                            rec_sum     = rec_sum + value[7:0];
                            parse_phase = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            rec_addr    = value;
                            rec_sum     = rec_sum + value[7:0] + value[15:8];
                            parse_phase = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            rec_sum = rec_sum + value[7:0];
                            if (value[7:0] == TYPE_DATA)
                            begin
                                parse_phase = (rec_count != 8'h00) ? PH_DATA : PH_CKSUM;
                            end
                            else
                            begin
                                parse_phase = PH_SKIP;
                                expect_result((value[7:0] == TYPE_EOF) ? K_EOF : K_UNKNOWN,
                                              rec_addr, 8'h00);
                            end
                        end
                        PH_DATA:
                        begin
                            rec_sum = rec_sum + value[7:0];
                            expect_result(K_DATA, rec_addr + 16'(rec_bytes), value[7:0]);
                            rec_bytes = rec_bytes + 8'd1;
                            if (rec_bytes == rec_count)
                                parse_phase = PH_CKSUM;
                        end
                        default:
                        begin
                            parse_phase = PH_SKIP;
                            total = rec_sum + value[7:0];
                            expect_result((total != 8'h00) ? K_CKSUM : K_OK, rec_addr, 8'h00);
                        end
                    endcase
                end
            end
        end
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (nibble_of(c) >= 0);
        return c;
    endfunction

    task automatic add_hex(logic [7:0] v);
        line_buf.push_back(hex_char(v[7:4]));
        line_buf.push_back(hex_char(v[3:0]));
    endtask

    // Builds one line into char_q. A positive spot places the bad digit or the
    // cut point; otherwise it is chosen at random inside the record.
    task automatic add_line(line_style_t style, int count, logic [15:0] addr,
                            int trailing, int spot);
        logic [7:0] rtype;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] first;
        int         body_len;
        int         keep;
        line_buf.delete();
        case (style)
            LINE_EMPTY:
            begin
            end
            LINE_NO_COLON:
            begin
                do
                    first = 8'($urandom_range(1, 255));
                while (first == COLON_CHAR);
                line_buf.push_back(first);
                repeat (trailing) line_buf.push_back(8'($urandom_range(1, 255)));
            end
            LINE_NOISE:
            begin
                repeat (trailing + 1) line_buf.push_back(8'($urandom_range(1, 255)));
            end
            default:
            begin
                if (style == LINE_EOF)
                    rtype = TYPE_EOF;
                else if (style == LINE_UNKNOWN)
                    rtype = 8'($urandom_range(2, 255));
                else
                    rtype = TYPE_DATA;
                line_buf.push_back(COLON_CHAR);
                add_hex(8'(count));
                add_hex(addr[15:8]);
                add_hex(addr[7:0]);
                add_hex(rtype);
                sum = 8'(count) + addr[15:8] + addr[7:0] + rtype;
                repeat (count)
                begin
                    b = 8'($urandom_range(0, 255));
                    add_hex(b);
                    sum = sum + b;
                end
                sum = 8'h00 - sum;
                if (style == LINE_BAD_SUM)
                    sum = sum + 8'($urandom_range(1, 255));
                add_hex(sum);
                body_len = line_buf.size();
                if (style == LINE_BAD_DIGIT)
                begin
                    line_buf[(spot > 0) ? spot : $urandom_range(1, body_len - 1)] =
                        random_non_hex();
                end
                else if (style == LINE_SHORT)
                begin
                    keep = (spot > 0) ? spot : $urandom_range(1, body_len - 1);
                    while (line_buf.size() > keep)
                        void'(line_buf.pop_back());
                end
                else
                begin
                    repeat (trailing) line_buf.push_back(8'($urandom_range(1, 255)));
                end
            end
        endcase
        foreach (line_buf[k])
            char_q.push_back(line_buf[k]);
        char_q.push_back(EOL_CHAR);
    endtask

    // Sender: offers characters from char_q, with random gaps between requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            calm          <= 1'b0;
        end
        else
        begin
            calm <= (char_q.size() <= CALM_TAIL);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (char_q.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= char_q.pop_front();
                    if (!calm && $urandom_range(0, 11) == 0)
                        send_gap = $urandom_range(1, 11);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off that backs up the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && chars_accepted >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: checks each result request, then predicts from each accepted character.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            parse_phase = PH_WAIT;
            clear_record();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, target_address %h, data_byte %h",
                           m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16]);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (m_axis_tuser !== oldest.kind)
                    begin
                        $error("kind: expected %0d, got %0d", oldest.kind, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[15:0] !== oldest.addr)
                    begin
                        $error("target_address: expected %h, got %h",
                               oldest.addr, m_axis_tdata[15:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[23:16] !== oldest.data)
                    begin
                        $error("data_byte: expected %h, got %h",
                               oldest.data, m_axis_tdata[23:16]);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_char(s_axis_tdata);
                chars_accepted <= chars_accepted + 1;
            end
        end
    end

    initial
    begin
        int          directed_len;
        int          pick;
        int          count;
        int          trailing;
        logic [15:0] addr;
        line_style_t style;

        // Directed lines: field extremes, every record type and every error path.
        add_line(LINE_EOF, 0, 16'h0000, 0, -1);
        add_line(LINE_GOOD, 0, 16'hFFFF, 0, -1);
        add_line(LINE_GOOD, 3, 16'hFFFE, 0, -1);
        add_line(LINE_BAD_SUM, 2, 16'h1234, 0, -1);
        add_line(LINE_UNKNOWN, 1, 16'hABCD, 0, -1);
        add_line(LINE_EOF, 2, 16'h8000, 3, -1);
        add_line(LINE_BAD_DIGIT, 1, 16'h0F0F, 0, 4);
        add_line(LINE_BAD_DIGIT, 2, 16'h5555, 0, 10);
        add_line(LINE_SHORT, 2, 16'h2222, 0, 9);
        add_line(LINE_SHORT, 1, 16'h3333, 0, 1);
        add_line(LINE_NO_COLON, 0, 16'h0000, 5, -1);
        add_line(LINE_EMPTY, 0, 16'h0000, 0, -1);
        add_line(LINE_GOOD, 4, 16'h7FFF, 4, -1);
        add_line(LINE_NOISE, 0, 16'h0000, 8, -1);
        add_line(LINE_GOOD, 255, 16'hFF80, 0, -1);
        directed_len = char_q.size();

        // Mostly well-formed records with random content, plus broken lines and noise.
        while (char_q.size() < directed_len + RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                style = LINE_GOOD;
            else if (pick < 63)
                style = LINE_BAD_SUM;
            else if (pick < 70)
                style = LINE_EOF;
            else if (pick < 77)
                style = LINE_UNKNOWN;
            else if (pick < 85)
                style = LINE_BAD_DIGIT;
            else if (pick < 91)
                style = LINE_SHORT;
            else if (pick < 95)
                style = LINE_NO_COLON;
            else if (pick < 97)
                style = LINE_EMPTY;
            else
                style = LINE_NOISE;
            count = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
            addr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                               : 16'($urandom_range(0, 16'hFFFF));
            if (style == LINE_NOISE || style == LINE_NO_COLON)
                trailing = $urandom_range(0, 12);
            else
                trailing = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
            add_line(style, count, addr, trailing, -1);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while ((char_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
               && cycle_count < CYCLE_LIMIT)
        begin
            @(negedge clk);
            cycle_count++;
        end

        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
        end
        else
        begin
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (pending_results.size() != 0)
            begin
                $error("%0d results never arrived", pending_results.size());
                mismatch_count++;
            end
            if (mismatch_count == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ihex_pkg.sv
hw/rtl/intel_hex_record_parser_core.sv
hw/rtl/ihex_chk.sv
dv/intel_hex_record_parser_core_test.sv
